@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; every macro reports through $error
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

@@ rtl/bq_pkg.sv @@
// shared widths, microcode types, program rom and saturation helpers
// for the direct form ii biquad; no dependencies
package bq_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int COEF_WIDTH   = 32;
	localparam int W_WIDTH      = SAMPLE_WIDTH + 8;
	localparam int CF           = COEF_WIDTH - 4;
	localparam int PROD_W       = COEF_WIDTH + W_WIDTH;
	localparam int ACC_W        = PROD_W + 2;
	localparam int RND_W        = ACC_W - CF;
	localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int CFG_IDX_W    = 8;
	localparam int NUM_STEPS    = 7;
	localparam int STEP_W       = $clog2(NUM_STEPS);

	localparam logic [COEF_WIDTH-1:0] COEF_B0_RST = COEF_WIDTH'(1) << CF;
	localparam logic [ACC_W-1:0]      ACC_HALF    = ACC_W'(1) << (CF - 1);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(4);

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		CSEL_B0,
		CSEL_B1,
		CSEL_B2,
		CSEL_A1,
		CSEL_A2
	} coef_sel_t;

	typedef enum logic [1:0] {
		OSEL_D1,
		OSEL_D2,
		OSEL_W
	} opnd_sel_t;

	typedef enum logic [2:0] {
		ACC_NOP,
		ACC_LOAD_X,
		ACC_LOAD_P,
		ACC_ADD_P,
		ACC_SUB_P
	} acc_op_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_IN,
		COND_OUT
	} cond_t;

	// datapath control, one per step
	typedef struct packed {
		logic      mul_en;
		coef_sel_t coef_sel;
		opnd_sel_t opnd_sel;
		acc_op_t   acc_op;
		logic      w_load;
		logic      out_load;
	} ctrl_t;

	typedef struct packed {
		cond_t cond;
		logic  last;
		ctrl_t ctrl;
	} ucode_t;

	localparam ctrl_t CTRL_NOP = '{
		mul_en: 1'b0, coef_sel: CSEL_B0, opnd_sel: OSEL_D1,
		acc_op: ACC_NOP, w_load: 1'b0, out_load: 1'b0};

	// program: feedback sum into w, then feedforward sum into the output
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t u;
		u.cond = COND_NONE;
		u.last = 1'b0;
		u.ctrl = CTRL_NOP;
		case (step)
			step_t'(0): begin
				u.cond = COND_IN;
				u.ctrl.acc_op = ACC_LOAD_X;
				u.ctrl.mul_en = 1'b1;
				u.ctrl.coef_sel = CSEL_A1;
				u.ctrl.opnd_sel = OSEL_D1;
			end
			step_t'(1): begin
				u.ctrl.acc_op = ACC_SUB_P;
				u.ctrl.mul_en = 1'b1;
				u.ctrl.coef_sel = CSEL_A2;
				u.ctrl.opnd_sel = OSEL_D2;
			end
			step_t'(2): begin
				u.ctrl.acc_op = ACC_SUB_P;
				u.ctrl.mul_en = 1'b1;
				u.ctrl.coef_sel = CSEL_B1;
				u.ctrl.opnd_sel = OSEL_D1;
			end
			step_t'(3): begin
				// w taken from the finished feedback sum
				u.ctrl.w_load = 1'b1;
				u.ctrl.acc_op = ACC_LOAD_P;
				u.ctrl.mul_en = 1'b1;
				u.ctrl.coef_sel = CSEL_B2;
				u.ctrl.opnd_sel = OSEL_D2;
			end
			step_t'(4): begin
				u.ctrl.acc_op = ACC_ADD_P;
				u.ctrl.mul_en = 1'b1;
				u.ctrl.coef_sel = CSEL_B0;
				u.ctrl.opnd_sel = OSEL_W;
			end
			step_t'(5): begin
				u.ctrl.acc_op = ACC_ADD_P;
			end
			step_t'(6): begin
				u.cond = COND_OUT;
				u.last = 1'b1;
				u.ctrl.out_load = 1'b1;
			end
			default: begin
				u.last = 1'b1;
			end
		endcase
		return u;
	endfunction

	function automatic logic [W_WIDTH-1:0] sat_w(input logic [RND_W-1:0] v);
		logic fits;
		logic [W_WIDTH-1:0] r;
		fits = (&v[RND_W-1:W_WIDTH-1]) || !(|v[RND_W-1:W_WIDTH-1]);
		if (fits) begin
			r = v[W_WIDTH-1:0];
		end else if (v[RND_W-1]) begin
			r = {1'b1, {(W_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(W_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [SAMPLE_WIDTH-1:0] sat_s(input logic [RND_W-1:0] v);
		logic fits;
		logic [SAMPLE_WIDTH-1:0] r;
		fits = (&v[RND_W-1:SAMPLE_WIDTH-1]) || !(|v[RND_W-1:SAMPLE_WIDTH-1]);
		if (fits) begin
			r = v[SAMPLE_WIDTH-1:0];
		end else if (v[RND_W-1]) begin
			r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

@@ rtl/bq_ucode_seq.sv @@
// microcode sequencer: step counter, program rom and stall conditions
// depends on bq_pkg
module bq_ucode_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          out_free,
	output logic          in_ready,
	output bq_pkg::ctrl_t ctrl
);

	bq_pkg::step_t  step_q;
	bq_pkg::ucode_t word;
	logic           stall;

	always_comb begin
		word  = bq_pkg::ucode_rom(step_q);
		stall = ((word.cond == bq_pkg::COND_IN) && !in_valid) ||
			((word.cond == bq_pkg::COND_OUT) && !out_free);
		ctrl  = stall ? bq_pkg::CTRL_NOP : word.ctrl;
		in_ready = (word.cond == bq_pkg::COND_IN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (!stall) begin
			step_q <= word.last ? '0 : step_q + bq_pkg::step_t'(1);
		end
	end

endmodule

@@ rtl/bq_datapath.sv @@
// coefficient registers, shared multiplier, accumulator, w and delay words
// depends on bq_pkg
module bq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bq_pkg::ctrl_t                    ctrl,
	input  logic [bq_pkg::SAMPLE_WIDTH-1:0]  sample_in,
	input  logic                             cfg_we,
	input  logic [bq_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [bq_pkg::COEF_WIDTH-1:0]    cfg_wdata,
	output logic [bq_pkg::SAMPLE_WIDTH-1:0]  sample_out
);

	logic [bq_pkg::COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [bq_pkg::W_WIDTH-1:0]      d1_q, d2_q, w_q;
	logic [bq_pkg::PROD_W-1:0]       prod_q;
	logic [bq_pkg::ACC_W-1:0]        acc_q;
	logic [bq_pkg::SAMPLE_WIDTH-1:0] out_q;
	logic [bq_pkg::COEF_WIDTH-1:0]   coef;
	logic [bq_pkg::W_WIDTH-1:0]      opnd;
	logic [bq_pkg::ACC_W-1:0]        prod_ext, x_ext, rnd;
	logic [bq_pkg::RND_W-1:0]        rnd_hi;

	always_comb begin
		case (ctrl.coef_sel)
			bq_pkg::CSEL_B0: coef = b0_q;
			bq_pkg::CSEL_B1: coef = b1_q;
			bq_pkg::CSEL_B2: coef = b2_q;
			bq_pkg::CSEL_A1: coef = a1_q;
			bq_pkg::CSEL_A2: coef = a2_q;
			default:         coef = b0_q;
		endcase
		case (ctrl.opnd_sel)
			bq_pkg::OSEL_D1: opnd = d1_q;
			bq_pkg::OSEL_D2: opnd = d2_q;
			bq_pkg::OSEL_W:  opnd = w_q;
			default:         opnd = d1_q;
		endcase
		prod_ext = bq_pkg::ACC_W'($signed(prod_q));
		x_ext    = bq_pkg::ACC_W'($signed(sample_in)) << bq_pkg::CF;
		// round half up, then drop the coefficient fraction bits
		rnd      = acc_q + bq_pkg::ACC_HALF;
		rnd_hi   = rnd[bq_pkg::ACC_W-1:bq_pkg::CF];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= bq_pkg::COEF_B0_RST;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					bq_pkg::REG_B0: b0_q <= cfg_wdata;
					bq_pkg::REG_B1: b1_q <= cfg_wdata;
					bq_pkg::REG_B2: b2_q <= cfg_wdata;
					bq_pkg::REG_A1: a1_q <= cfg_wdata;
					bq_pkg::REG_A2: a2_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (ctrl.out_load) begin
				d2_q <= d1_q;
				d1_q <= w_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= bq_pkg::PROD_W'($signed(coef) * $signed(opnd));
		end
		case (ctrl.acc_op)
			bq_pkg::ACC_LOAD_X: acc_q <= x_ext;
			bq_pkg::ACC_LOAD_P: acc_q <= prod_ext;
			bq_pkg::ACC_ADD_P:  acc_q <= acc_q + prod_ext;
			bq_pkg::ACC_SUB_P:  acc_q <= acc_q - prod_ext;
			default: ;
		endcase
		if (ctrl.w_load) begin
			w_q <= bq_pkg::sat_w(rnd_hi);
		end
		if (ctrl.out_load) begin
			out_q <= bq_pkg::sat_s(rnd_hi);
		end
	end

	assign sample_out = out_q;

endmodule

@@ rtl/biquad_iir_filter_df2.sv @@
// top level of the direct form ii biquad: stream ports, output register
// depends on bq_pkg, bq_ucode_seq, bq_datapath
//
//   port group  dir  handshake                transfer carries
//   s_axis      in   s_axis_tvalid/tready     sample_in
//   m_axis      out  m_axis_tvalid/tready     sample_out
//   cfg         in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// one sample runs the 7-step program, so the next input transfer waits for the
// last step, which loads the result into the output register once it is free.
// all five products go through one shared 32x32 multiplier.
// the next sample is taken while a result waits in the output register.
// a result that is not taken holds the program at its last step.
// reset sets b0 to 1.0, all other coefficients and both delays to zero.
// cfg_ready is always high; writes to an index above 4 are dropped.
module biquad_iir_filter_df2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bq_pkg::TDATA_W-1:0]    s_axis_tdata,  // [23:0] sample_in
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bq_pkg::TDATA_W-1:0]    m_axis_tdata,  // [23:0] sample_out
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bq_pkg::COEF_WIDTH-1:0] cfg_data
);

	bq_pkg::ctrl_t                   ctrl;
	logic                            out_valid_q;
	logic                            out_free;
	logic [bq_pkg::SAMPLE_WIDTH-1:0] sample_out;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	bq_ucode_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	bq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample_in  (s_axis_tdata[bq_pkg::SAMPLE_WIDTH-1:0]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.sample_out (sample_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = bq_pkg::TDATA_W'(sample_out);

endmodule

@@ rtl/bq_checker.sv @@
// port-level checks for the biquad top level, attached by bind
// depends on bq_pkg and assert_macros.svh
`include "assert_macros.svh"

module bq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [bq_pkg::TDATA_W-1:0]    m_axis_tdata,
	input logic                          cfg_ready
);

	// a waiting result neither drops nor changes
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

	// one sample at a time: input closes right after a transfer
	`ASSERT_CLK(a_in_busy, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

	// a new result only ever appears while a sample is in work
	`ASSERT_CLK(a_out_from_work, clk, arst_n, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

	// the configuration channel never back-pressures
	`ASSERT_ALWAYS(a_cfg_open, clk, cfg_ready)

endmodule

bind biquad_iir_filter_df2 bq_checker u_bq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);

@@ dv/biquad_iir_filter_df2_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the direct form ii biquad: directed extremes, then random
// coefficient sets and samples under varied idling; needs bq_pkg and biquad_iir_filter_df2
module biquad_iir_filter_df2_tb;
	import bq_pkg::*;

	localparam int SUM_W = COEF_WIDTH + W_WIDTH + 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 192;

	// expected filter output, tracked from accepted samples and register writes
	class biquad_scoreboard;
		logic signed [COEF_WIDTH-1:0] ff0, ff1, ff2, fb1, fb2;
		logic signed [W_WIDTH-1:0] z1, z2;
		logic [SAMPLE_WIDTH-1:0] expected_out[$];
		int unsigned fails;

		function new();
			ff0 = COEF_B0_RST;
			ff1 = '0;
			ff2 = '0;
			fb1 = '0;
			fb2 = '0;
			z1 = '0;
			z2 = '0;
			fails = 0;
		endfunction

		function bit busy();
			return expected_out.size() != 0;
		endfunction

		function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_WIDTH-1:0] val);
			case (idx)
				REG_B0: ff0 = val;
				REG_B1: ff1 = val;
				REG_B2: ff2 = val;
				REG_A1: fb1 = val;
				REG_A2: fb2 = val;
				default: ;
			endcase
		endfunction

		// round half up onto the sample grid, then clamp to a signed range of bits
		function logic signed [W_WIDTH-1:0] round_clamp(logic signed [SUM_W-1:0] acc, int bits);
			logic signed [SUM_W-1:0] r, hi, lo;
			r = (acc + (SUM_W'(1) <<< (CF - 1))) >>> CF;
			hi = (SUM_W'(1) <<< (bits - 1)) - 1;
			lo = -(SUM_W'(1) <<< (bits - 1));
			if (r > hi) begin
				r = hi;
			end else if (r < lo) begin
				r = lo;
			end
			return r[W_WIDTH-1:0];
		endfunction

		function logic [SAMPLE_WIDTH-1:0] filter_sample(logic [SAMPLE_WIDTH-1:0] x);
			logic signed [SUM_W-1:0] acc, prod;
			logic signed [W_WIDTH-1:0] w, y;
			acc = $signed(x);
			acc = acc <<< CF;
			prod = fb1 * z1;
			acc = acc - prod;
			prod = fb2 * z2;
			acc = acc - prod;
			w = round_clamp(acc, W_WIDTH);
			acc = ff0 * w;
			prod = ff1 * z1;
			acc = acc + prod;
			prod = ff2 * z2;
			acc = acc + prod;
			y = round_clamp(acc, SAMPLE_WIDTH);
			z2 = z1;
			z1 = w;
			return y[SAMPLE_WIDTH-1:0];
		endfunction

		function void note_sample(logic [SAMPLE_WIDTH-1:0] x);
			expected_out.push_back(filter_sample(x));
		endfunction

		function void check_sample(logic [SAMPLE_WIDTH-1:0] y);
			logic [SAMPLE_WIDTH-1:0] exp_y;
			if (expected_out.size() == 0) begin
				$display("%0t: sample_out with nothing pending, actual %0d", $time, $signed(y));
				fails++;
			end else begin
				exp_y = expected_out.pop_front();
				if (y !== exp_y) begin
					$display("%0t: sample_out expected %0d, actual %0d",
						$time, $signed(exp_y), $signed(y));
					fails++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_WIDTH-1:0] cfg_data = '0;

	biquad_scoreboard sb;
	int sender_idle = 0;
	int recv_stall = 0;
	int unsigned cycles = 0;

	biquad_iir_filter_df2 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	// every transfer on the three channels goes through here
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_coef(cfg_index, cfg_data);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_sample(s_axis_tdata[SAMPLE_WIDTH-1:0]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_sample(m_axis_tdata[SAMPLE_WIDTH-1:0]);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic feed(input logic [SAMPLE_WIDTH-1:0] x);
		if ($urandom_range(99) < sender_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= TDATA_W'(x);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// wait until every expected sample is out and the datapath has gone quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.busy());
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_WIDTH-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// one unmapped write first, which must leave the filter untouched
	task automatic load_coefs(input logic [COEF_WIDTH-1:0] b0, b1, b2, a1, a2);
		write_reg(CFG_IDX_W'($urandom_range(255, int'(REG_A2) + 1)), $urandom);
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [COEF_WIDTH-1:0] extreme_coef();
		case ($urandom_range(6))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'h1000_0000;
			4: return 32'hF000_0000;
			5: return 32'hFFFF_FFFF;
			default: return 32'h0000_0001;
		endcase
	endfunction

	function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return 24'h7F_FFFF;
					1: return 24'h80_0000;
					2: return 24'h00_0000;
					3: return 24'hFF_FFFF;
					default: return 24'h00_0001;
				endcase
			end
			1, 2: return 24'($urandom_range(8191) - 4096);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic pick_coefs(input int mode);
		longint a1_lim, a2v, a1v;
		logic [COEF_WIDTH-1:0] b0, b1, b2;
		case (mode)
			0: begin
				// poles inside the unit circle, gains within +/-1
				a2v = longint'($urandom_range(2 * 214748364)) - 214748364;
				a1_lim = ((268435456 + a2v) * 9) / 10;
				a1v = longint'($urandom_range(32'(2 * a1_lim))) - a1_lim;
				b0 = 32'($urandom_range(1 << 29) - (1 << 28));
				b1 = 32'($urandom_range(1 << 29) - (1 << 28));
				b2 = 32'($urandom_range(1 << 29) - (1 << 28));
				load_coefs(b0, b1, b2, 32'(a1v), 32'(a2v));
			end
			1: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
			default: load_coefs(extreme_coef(), extreme_coef(), extreme_coef(),
				extreme_coef(), extreme_coef());
		endcase
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients pass samples straight through
		feed(24'h7F_FFFF);
		feed(24'h80_0000);
		feed(24'h00_0000);
		feed(24'hFF_FFFF);
		feed(24'h00_0001);
		feed(24'h55_5555);
		feed(24'hAA_AAAA);
		settle();

		// largest gains and feedback: w and the output both hit their rails
		load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		repeat (4) feed(24'h7F_FFFF);
		repeat (4) feed(24'h80_0000);
		feed(24'h00_0000);
		feed(24'h00_0001);
		settle();
		load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		feed(24'h80_0000);
		feed(24'h7F_FFFF);
		feed(24'h00_0000);
		feed(24'h80_0000);
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p % 4)
				0: begin
					sender_idle = 0;
					recv_stall = 0;
				end
				1: begin
					sender_idle = 73;
					recv_stall = 0;
				end
				2: begin
					sender_idle = 0;
					recv_stall = 73;
				end
				default: begin
					sender_idle = 16;
					recv_stall = 16;
				end
			endcase
			pick_coefs(p % 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				feed(rand_sample());
			end
			settle();
		end

		if (sb.fails == 0 && !sb.busy()) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
